[hw/rtl/set_associative_lru_cache_tags_core_defines.svh]
// Assertion macros for the cache tag core.
// Included by the RTL files that carry checks; no other dependencies.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_TAGS_CORE_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_TAGS_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while in reset
`define SALC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication, sampled on clk, off while in reset
`define SALC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SALC_ASSERT_IMP(lbl, ante, cons)
`define SALC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/salc_pkg.sv]
// Shared types and constants for the cache tag core.
// No dependencies; imported by the core and its statistics counters.
package salc_pkg;

    localparam int ADDR_W     = 32;
    localparam int OFFSET_W   = 5;
    localparam int COUNT_W    = 64;
    localparam int WAY_OUT_W  = 2;

    localparam logic [OFFSET_W-1:0] MAX_OFFSET   = 5'd16;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd6;

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef struct packed {
        count_t write_hits;
        count_t write_requests;
        count_t read_hits;
        count_t read_requests;
    } stats_t;

endpackage

[hw/rtl/set_associative_lru_cache_tags_core.sv]
// Tag-only set-associative cache with true LRU replacement. Each access
// (s_tuser: 0 read, 1 write; s_tdata: byte address) returns one result with
// hit, way and four wrapping 64-bit counters. Set rows (tags, valid bits,
// recency order) live in one memory with a registered read and one write
// port; an access is accepted in one cycle and looked up in the next, so the
// block sustains one access per cycle while m_tready does not stall it, the
// written row being forwarded when the following access hits the same set.
// Results leave through an output register loaded when the lookup fires.
// After reset a clearing pass writes every row once while s_tready stays
// low; offset_bits writes are taken throughout. Values of offset_bits above
// 16 act as 16, and changing it does not flush the stored tags.
`include "set_associative_lru_cache_tags_core_defines.svh"
module set_associative_lru_cache_tags_core #(
    parameter int SET_BITS = 7,
    parameter int WAYS     = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: offset_bits
    input  logic                          cfg_wr_en,
    input  logic [salc_pkg::OFFSET_W-1:0] cfg_wr_data,
    // access stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // [31:0] addr
    input  salc_pkg::op_t                 s_tuser,  // [0] op
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] hit, [2:1] way, [66:3] read_requests, [130:67] read_hits,
    // [194:131] write_requests, [258:195] write_hits, [263:259] zero
    output logic [263:0]                  m_tdata
);

    import salc_pkg::*;

    localparam int SETS    = 1 << SET_BITS;
    localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W   = ADDR_W - SET_BITS;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VAL_LO  = WAYS * TAG_W;
    localparam int ORD_LO  = VAL_LO + WAYS;
    localparam int ROW_W   = ORD_LO + WAYS * WAY_W;
    localparam int RES_W   = 1 + WAY_OUT_W + 4 * COUNT_W;
    localparam int OUT_W   = 264;

    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SET_W-1:0]      clr_cnt_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    logic [ROW_W-1:0]      mem [SETS];
    logic [ROW_W-1:0]      rd_row_reg;
    logic [ROW_W-1:0]      wb_row_reg;
    logic                  fwd_reg;

    logic                  stg_valid_reg;
    op_t                   stg_op_reg;
    logic [SET_W-1:0]      stg_set_reg;
    logic [TAG_W-1:0]      stg_tag_reg;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    logic [OFFSET_W-1:0]   ob;
    logic [ADDR_W-1:0]     shifted;
    logic [SET_W-1:0]      acc_set;
    logic [TAG_W-1:0]      acc_tag;
    logic                  acc;
    logic                  stg_fire;

    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      new_row;
    logic [ROW_W-1:0]      clr_row;
    logic                  lk_hit;
    logic [WAY_W-1:0]      lk_way;
    logic [WAYS*TAG_W-1:0] lk_tags;
    logic [WAYS-1:0]       lk_valid;
    logic [WAYS*WAY_W-1:0] lk_order;

    logic                  mem_we;
    logic [SET_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    stats_t                cnt_next;

    // Split the address into set and tag
    always_comb
    begin
        ob      = (offset_reg > MAX_OFFSET) ? MAX_OFFSET : offset_reg;
        shifted = s_tdata[ADDR_W-1:0] >> ob;
        acc_set = shifted[SET_W-1:0] & SET_MASK;
        acc_tag = TAG_W'(shifted >> SET_BITS);
    end

    // Handshake
    assign stg_fire = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_RUN) && (!stg_valid_reg || stg_fire);
    assign acc      = s_tvalid && s_tready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    // Clearing pass, then normal running
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_MASK)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
        end
    end

    // Row written during the clearing pass: nothing valid, order 0..WAYS-1
    always_comb
    begin
        clr_row = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            clr_row[ORD_LO + j*WAY_W +: WAY_W] = WAY_W'(j);
        end
    end

    // Pick the freshest copy of the row
    assign cur_row = fwd_reg ? wb_row_reg : rd_row_reg;

    salc_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_lookup (
        .tag       (stg_tag_reg),
        .row_tags  (cur_row[VAL_LO-1:0]),
        .row_valid (cur_row[ORD_LO-1:VAL_LO]),
        .row_order (cur_row[ROW_W-1:ORD_LO]),
        .hit       (lk_hit),
        .way       (lk_way),
        .new_tags  (lk_tags),
        .new_valid (lk_valid),
        .new_order (lk_order)
    );

    assign new_row = {lk_order, lk_valid, lk_tags};

    // Memory write port: clearing pass or write-back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = stg_set_reg;
        mem_wdata = new_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = clr_row;
        end
        else if (stg_fire)
        begin
            mem_we = 1'b1;
        end
    end

    // Set row memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (acc)
        begin
            rd_row_reg <= mem[acc_set];
        end
    end

    // Keep the last written row for a same-set follower
    always_ff @(posedge clk)
    begin
        if (stg_fire)
        begin
            wb_row_reg <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (acc)
        begin
            fwd_reg <= stg_fire && (acc_set == stg_set_reg);
        end
    end

    // Lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (stg_fire)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            stg_op_reg  <= s_tuser;
            stg_set_reg <= acc_set;
            stg_tag_reg <= acc_tag;
        end
    end

    salc_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (stg_fire),
        .op       (stg_op_reg),
        .hit      (lk_hit),
        .cnt_next (cnt_next)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire)
        begin
            out_data_reg <= {(OUT_W - RES_W)'(0),
                             cnt_next.write_hits, cnt_next.write_requests,
                             cnt_next.read_hits, cnt_next.read_requests,
                             WAY_OUT_W'(lk_way), lk_hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `SALC_ASSERT_IMP(a_no_accept_clearing, state_reg == ST_CLEAR, !s_tready)
    `SALC_ASSERT_IMP(a_stage_empty_clearing, state_reg == ST_CLEAR, !stg_valid_reg)
    `SALC_ASSERT_NXT(a_fire_gives_result, stg_fire, m_tvalid)
    `SALC_ASSERT_IMP(a_fwd_after_writeback, fwd_reg && stg_valid_reg,
                     $past(stg_fire) || $past(!acc))

endmodule

[hw/rtl/salc_lookup.sv]
// Tag compare, victim choice and LRU reorder for one set row.
// Purely combinational; no package dependency.
module salc_lookup #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 25,
    parameter int WAY_W = 2
) (
    input  logic [TAG_W-1:0]      tag,
    input  logic [WAYS*TAG_W-1:0] row_tags,
    input  logic [WAYS-1:0]       row_valid,
    input  logic [WAYS*WAY_W-1:0] row_order,
    output logic                  hit,
    output logic [WAY_W-1:0]      way,
    output logic [WAYS*TAG_W-1:0] new_tags,
    output logic [WAYS-1:0]       new_valid,
    output logic [WAYS*WAY_W-1:0] new_order
);

    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic             found;
    logic [WAY_W-1:0] pos;

    // Compare all ways; the lowest matching way wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_valid[w] && (row_tags[w*TAG_W +: TAG_W] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Take the least recent way as victim, guarding against a stray code
    always_comb
    begin
        victim = row_order[WAY_W-1:0];
        if (32'(victim) >= WAYS)
        begin
            victim = '0;
        end
        way = hit ? hit_way : victim;
    end

    // Refill the victim on a miss
    always_comb
    begin
        new_tags  = row_tags;
        new_valid = row_valid;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && (victim == WAY_W'(w)))
            begin
                new_tags[w*TAG_W +: TAG_W] = tag;
                new_valid[w]               = 1'b1;
            end
        end
    end

    // Locate the used way in the order list
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_order[i*WAY_W +: WAY_W] == way)
            begin
                found = 1'b1;
                pos   = WAY_W'(i);
            end
        end
    end

    // Close the gap and move the used way to the most recent end
    always_comb
    begin
        new_order = row_order;
        for (int j = 0; j < WAYS; j++)
        begin
            if (found && (WAY_W'(j) >= pos))
            begin
                if (j == WAYS - 1)
                begin
                    new_order[j*WAY_W +: WAY_W] = way;
                end
                else
                begin
                    new_order[j*WAY_W +: WAY_W] = row_order[(j+1)*WAY_W +: WAY_W];
                end
            end
        end
    end

endmodule

[hw/rtl/salc_stats.sv]
// Wrapping read/write request and hit counters.
// Depends on salc_pkg for the counter and access types.
module salc_stats (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd,
    input  salc_pkg::op_t    op,
    input  logic             hit,
    output salc_pkg::stats_t cnt_next
);

    import salc_pkg::*;

    stats_t cnt_reg;

    // Work out the counts including the current access
    always_comb
    begin
        cnt_next = cnt_reg;
        if (upd)
        begin
            if (op == OP_WRITE)
            begin
                cnt_next.write_requests = cnt_reg.write_requests + count_t'(1);
                if (hit)
                begin
                    cnt_next.write_hits = cnt_reg.write_hits + count_t'(1);
                end
            end
            else
            begin
                cnt_next.read_requests = cnt_reg.read_requests + count_t'(1);
                if (hit)
                begin
                    cnt_next.read_hits = cnt_reg.read_hits + count_t'(1);
                end
            end
        end
    end

    // Hold the counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[tb/tb_set_associative_lru_cache_tags_core.sv]
// Self-checking testbench for set_associative_lru_cache_tags_core: read and write
// accesses with random stalls on both streams, checked against an LRU tag model.
// Depends on salc_pkg and the core RTL; stands alone otherwise.

localparam int TAG_SET_BITS = 7;
localparam int TAG_WAYS     = 4;
localparam int TAG_SETS     = 1 << TAG_SET_BITS;

typedef struct packed {
    logic             hit;
    logic [1:0]       way;
    salc_pkg::count_t read_requests;
    salc_pkg::count_t read_hits;
    salc_pkg::count_t write_requests;
    salc_pkg::count_t write_hits;
} lookup_result_t;

// Tag store, valid bits and recency order kept alongside the block
class lru_tag_checker;
    logic [4:0]       offset_bits;
    bit               valid_bits [TAG_SETS][TAG_WAYS];
    logic [31:0]      tag_store [TAG_SETS][TAG_WAYS];
    logic [1:0]       recency [TAG_SETS][TAG_WAYS];
    salc_pkg::count_t read_count;
    salc_pkg::count_t read_hit_count;
    salc_pkg::count_t write_count;
    salc_pkg::count_t write_hit_count;
    lookup_result_t   expected_lookups [$];
    int               errors;
    int               accesses;
    int               hits;

    function new();
        offset_bits = salc_pkg::OFFSET_RESET;
        for (int s = 0; s < TAG_SETS; s++)
        begin
            for (int w = 0; w < TAG_WAYS; w++)
            begin
                valid_bits[s][w] = 1'b0;
                tag_store[s][w]  = '0;
                recency[s][w]    = 2'(w);
            end
        end
        read_count      = '0;
        read_hit_count  = '0;
        write_count     = '0;
        write_hit_count = '0;
        errors          = 0;
        accesses        = 0;
        hits            = 0;
    endfunction

    function void set_offset(logic [4:0] value);
        offset_bits = value;
    endfunction

    function int pending();
        return expected_lookups.size();
    endfunction

    // Look up one accepted access, update the set and queue the expected result
    function void note_access(salc_pkg::op_t op, logic [31:0] addr);
        int unsigned    shift;
        int unsigned    set_idx;
        int unsigned    way_idx;
        int unsigned    pos;
        logic [31:0]    tag;
        bit             found;
        lookup_result_t res;
        shift   = 32'((offset_bits > salc_pkg::MAX_OFFSET) ? salc_pkg::MAX_OFFSET
                                                             : offset_bits);
        set_idx = (addr >> shift) & (TAG_SETS - 1);
        tag     = addr >> (shift + TAG_SET_BITS);
        found   = 1'b0;
        way_idx = 0;
        for (int w = 0; w < TAG_WAYS && !found; w++)
        begin
            if (valid_bits[set_idx][w] && tag_store[set_idx][w] == tag)
            begin
                found   = 1'b1;
                way_idx = w;
            end
        end
        // refill the least recent way on a miss
        if (!found)
        begin
            way_idx = 32'(recency[set_idx][0]);
            tag_store[set_idx][way_idx]  = tag;
            valid_bits[set_idx][way_idx] = 1'b1;
        end
        // move the way to the most recent end
        pos = 0;
        for (int i = 0; i < TAG_WAYS; i++)
        begin
            if (recency[set_idx][i] == way_idx)
                pos = i;
        end
        for (int i = pos; i < TAG_WAYS - 1; i++)
            recency[set_idx][i] = recency[set_idx][i + 1];
        recency[set_idx][TAG_WAYS - 1] = 2'(way_idx);
        if (op == salc_pkg::OP_WRITE)
        begin
            write_count++;
            if (found)
                write_hit_count++;
        end
        else
        begin
            read_count++;
            if (found)
                read_hit_count++;
        end
        accesses++;
        if (found)
            hits++;
        res.hit            = found;
        res.way            = 2'(way_idx);
        res.read_requests  = read_count;
        res.read_hits      = read_hit_count;
        res.write_requests = write_count;
        res.write_hits     = write_hit_count;
        expected_lookups.push_back(res);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    // Match one result transfer against the oldest expectation
    function void check_result(logic [263:0] data);
        lookup_result_t want;
        if (expected_lookups.size() == 0)
        begin
            $display("%0t: result with no access outstanding, expected none, actual %h",
                     $time, data);
            errors++;
            return;
        end
        want = expected_lookups.pop_front();
        compare_field("hit", 64'(want.hit), 64'(data[0]));
        compare_field("way", 64'(want.way), 64'(data[2:1]));
        compare_field("read_requests", want.read_requests, data[66:3]);
        compare_field("read_hits", want.read_hits, data[130:67]);
        compare_field("write_requests", want.write_requests, data[194:131]);
        compare_field("write_hits", want.write_hits, data[258:195]);
    endfunction
endclass

module tb_set_associative_lru_cache_tags_core;
    timeunit 1ns;
    timeprecision 1ps;
    import salc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int IDLE_PERCENT   = 38;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ACCESSES = 140;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [OFFSET_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata     = '0;  // [31:0] addr
    op_t                 s_tuser     = OP_READ;  // [0] op
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    // [0] hit, [2:1] way, [66:3] read_requests, [130:67] read_hits,
    // [194:131] write_requests, [258:195] write_hits, [263:259] zero
    logic [263:0]        m_tdata;

    bit                  no_idle     = 1'b0;
    int unsigned         cycle_count = 0;
    int                  offset_writes = 0;
    lru_tag_checker      tag_model;
    logic [31:0]         recent_addrs [$];

    set_associative_lru_cache_tags_core #(
        .SET_BITS (TAG_SET_BITS),
        .WAYS     (TAG_WAYS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the result stream at random
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tag_model.check_result(m_tdata);
    end

    function automatic int unsigned block_shift();
        return 32'((tag_model.offset_bits > MAX_OFFSET) ? MAX_OFFSET
                                                         : tag_model.offset_bits);
    endfunction

    function automatic logic [31:0] compose_addr(int unsigned shift, int unsigned set_idx,
                                                 logic [31:0] tag, logic [31:0] low);
        logic [31:0] mask;
        mask = (32'd1 << shift) - 32'd1;
        return (tag << (shift + TAG_SET_BITS)) | (set_idx << shift) | (low & mask);
    endfunction

    // Offer one access and hold it until the transfer completes
    task automatic send_access(op_t op, logic [31:0] addr);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        tag_model.note_access(op, addr);
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 16)
            void'(recent_addrs.pop_front());
    endtask

    // Hold off the access stream until every result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tag_model.pending() != 0);
    endtask

    task automatic write_offset(logic [4:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tag_model.set_offset(value);
        offset_writes++;
    endtask

    // Replay a recent address, sometimes with other offset bits
    task automatic send_recent_access();
        logic [31:0] addr;
        logic [31:0] mask;
        mask = (32'd1 << block_shift()) - 32'd1;
        addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        if ($urandom_range(0, 1))
            addr = (addr & ~mask) | ($urandom & mask);
        send_access(op_t'($urandom_range(0, 1)), addr);
    endtask

    // Mostly a few hot sets with a handful of tags, so hits and evictions dominate
    task automatic send_random_access();
        int unsigned shift;
        int unsigned pick;
        logic [31:0] addr;
        shift = block_shift();
        pick  = $urandom_range(0, 99);
        if (pick < 50)
            addr = compose_addr(shift, $urandom_range(0, 3), $urandom_range(0, 5), $urandom);
        else if (pick < 75)
        begin
            send_recent_access();
            return;
        end
        else if (pick < 90)
            addr = compose_addr(shift, $urandom_range(0, TAG_SETS - 1),
                                $urandom_range(0, 7), $urandom);
        else
            addr = $urandom;
        send_access(op_t'($urandom_range(0, 1)), addr);
    endtask

    task automatic run_directed();
        // address extremes
        send_access(OP_READ, 32'h0000_0000);
        send_access(OP_WRITE, 32'h0000_0000);
        send_access(OP_READ, 32'hFFFF_FFFF);
        send_access(OP_WRITE, 32'hFFFF_FFC0);
        send_access(OP_WRITE, 32'h8000_0000);
        send_access(OP_READ, 32'h8000_003F);
        // fill one set, then force evictions of the least recent way back to back
        for (int t = 1; t <= 4; t++)
            send_access(OP_WRITE, compose_addr(6, 5, t, 0));
        send_access(OP_READ, compose_addr(6, 5, 1, 32'h3F));
        send_access(OP_READ, compose_addr(6, 5, 5, 0));
        send_access(OP_WRITE, compose_addr(6, 5, 2, 0));
        send_access(OP_READ, compose_addr(6, 5, 4, 0));
        send_access(OP_WRITE, compose_addr(6, 5, 1, 0));
        send_access(OP_READ, compose_addr(6, 5, 3, 0));
        send_access(OP_WRITE, compose_addr(6, 5, 3, 32'h15));
        send_access(OP_READ, compose_addr(6, 5, 5, 0));
    endtask

    initial
    begin
        logic [4:0] offsets [6];
        tag_model = new();
        offsets = '{5'd0, 5'd16, 5'd31, 5'd17, 5'($urandom_range(0, 31)), OFFSET_RESET};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int i = 0; i < PHASE_ACCESSES; i++)
            send_random_access();

        // change the block size without a flush; old tags stay and are compared as stored
        for (int p = 0; p < 6; p++)
        begin
            write_offset(offsets[p]);
            no_idle = (p == 1);
            for (int i = 0; i < 8; i++)
                send_recent_access();
            for (int i = 0; i < PHASE_ACCESSES; i++)
            begin
                if (i == PHASE_ACCESSES / 2)
                    wait_results_drained();
                send_random_access();
            end
        end
        no_idle = 1'b0;

        wait_results_drained();
        repeat (4) @(posedge clk);
        $display("Checked %0d accesses (%0d hits) across %0d block-size settings,",
                 tag_model.accesses, tag_model.hits, offset_writes + 1);
        $display("including offsets 0, 16 and above 16, with %0d mismatches",
                 tag_model.errors);
        if (tag_model.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/salc_pkg.sv
hw/rtl/salc_lookup.sv
hw/rtl/salc_stats.sv
hw/rtl/set_associative_lru_cache_tags_core.sv
tb/tb_set_associative_lru_cache_tags_core.sv
